>>> sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted set table: word widths, the
// operation codes and the result status codes.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned STATUS_W = 3;

  // operation carried by an input word
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  // status carried by a result word
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BADPOS = 3'd4
  } status_e;

endpackage

>>> sv/sorted_set_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_set_table_unit
// Fixed-capacity set of signed words kept in ascending order with no
// duplicates. Push inserts in sorted place, pop removes by 1-based position.
// Entries live in one synchronous RAM; a sequencer walks it one slot a cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o   | opcode_i, value_i, position_i
//  out     | output    | out_valid_o / out_ready_i | status_o, popped_value_o,
//          |           |                           | stored_count_o
//
//  push: scans up one RAM slot per cycle, carrying larger entries one slot higher
//  pop: moves the later entries down one slot per cycle
//  rejected words (full, empty, bad position) skip the RAM walk; a duplicate ends
//  the scan where it is found
//  reset clears count and control state, not the RAM; RAM is never read before written
//  a word is accepted only when the sequencer is idle; a waiting result does
//  not block the next accept, but the next result waits for the output register
// ----------------------------------------------------------------------------
module sorted_set_table_unit #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic signed [sst_pkg::WORD_W-1:0]   value_i,
  input  logic [sst_pkg::POS_W-1:0]           position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sst_pkg::STATUS_W-1:0]        status_o,
  output logic signed [sst_pkg::WORD_W-1:0]   popped_value_o,
  output logic [sst_pkg::COUNT_W-1:0]         stored_count_o
);
  import sst_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_TAKE,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             count_q;
  logic [AW-1:0]             idx_q;
  logic signed [WORD_W-1:0]  val_q;
  logic signed [WORD_W-1:0]  carry_q;
  logic signed [WORD_W-1:0]  taken_q;
  logic                      found_q;
  status_e                   res_q;
  logic                      out_valid_q;
  status_e                   status_q;
  logic signed [WORD_W-1:0]  popped_q;
  logic [COUNT_W-1:0]        count_out_q;

  // entry RAM
  logic signed [WORD_W-1:0]  mem_q [CAPACITY];
  logic signed [WORD_W-1:0]  rdata_q;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [WORD_W-1:0]  wr_data;

  // decode helpers
  logic            accept;
  logic            is_full;
  logic            is_empty;
  logic            pos_bad;
  logic [PW-1:0]   pos_m1;
  logic            last;
  logic            hit;
  logic            shift;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CW'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign pos_bad    = (position_i == '0) || (PW'(position_i) > PW'(count_q));
  assign pos_m1     = PW'(position_i) - PW'(1);
  assign last       = (CW'(idx_q) == (count_q - CW'(1)));
  assign hit        = !found_q && (rdata_q == val_q);
  assign shift      = found_q || (rdata_q > val_q);

  // ram port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = carry_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_e'(opcode_i) == OP_PUSH) begin
            rd_en = !is_full && !is_empty;
          end else begin
            rd_en   = !is_empty && !pos_bad;
            rd_addr = pos_m1[AW-1:0];
          end
        end
      end
      S_SCAN: begin
        wr_en   = !hit && shift;
        rd_en   = !hit && !last;
        rd_addr = idx_q + AW'(1);
      end
      S_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = count_q[AW-1:0];
      end
      S_TAKE: begin
        rd_en   = !last;
        rd_addr = idx_q + AW'(1);
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q - AW'(1);
        wr_data = rdata_q;
        rd_en   = !last;
        rd_addr = idx_q + AW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ram array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      carry_q     <= '0;
      taken_q     <= '0;
      found_q     <= 1'b0;
      res_q       <= ST_OK;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      popped_q    <= '0;
      count_out_q <= '0;
    end else begin
      // result register handshake
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q   <= value_i;
            carry_q <= value_i;
            taken_q <= '0;
            found_q <= 1'b0;
            idx_q   <= '0;
            if (opcode_e'(opcode_i) == OP_PUSH) begin
              priority if (is_full) begin
                res_q   <= ST_FULL;
                state_q <= S_DONE;
              end else if (is_empty) begin
                state_q <= S_TAIL;
              end else begin
                state_q <= S_SCAN;
              end
            end else begin
              priority if (is_empty) begin
                res_q   <= ST_EMPTY;
                state_q <= S_DONE;
              end else if (pos_bad) begin
                res_q   <= ST_BADPOS;
                state_q <= S_DONE;
              end else begin
                idx_q   <= pos_m1[AW-1:0];
                state_q <= S_TAKE;
              end
            end
          end
        end
        // walk up through the entries, carrying each one above the value one slot higher; stop on a duplicate
        S_SCAN: begin
          if (hit) begin
            res_q   <= ST_DUP;
            state_q <= S_DONE;
          end else begin
            if (shift) begin
              carry_q <= rdata_q;
              found_q <= 1'b1;
            end
            if (last) begin
              state_q <= S_TAIL;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end
        end
        // top slot gets the carried word
        S_TAIL: begin
          count_q <= count_q + CW'(1);
          res_q   <= ST_OK;
          state_q <= S_DONE;
        end
        S_TAKE: begin
          taken_q <= rdata_q;
          if (last) begin
            count_q <= count_q - CW'(1);
            res_q   <= ST_OK;
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_SHIFT;
          end
        end
        // close the gap one slot a cycle
        S_SHIFT: begin
          if (last) begin
            count_q <= count_q - CW'(1);
            res_q   <= ST_OK;
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            status_q    <= res_q;
            popped_q    <= taken_q;
            count_out_q <= COUNT_W'(count_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign stored_count_o = count_out_q;

endmodule

>>> sv/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the result channel of the sorted set table.
// ----------------------------------------------------------------------------
module sst_checker #(
  parameter int unsigned CAPACITY = 8
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [sst_pkg::STATUS_W-1:0]      status_o,
  input logic signed [sst_pkg::WORD_W-1:0] popped_value_o,
  input logic [sst_pkg::COUNT_W-1:0]       stored_count_o
);
  import sst_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(popped_value_o) && $stable(stored_count_o))
    else $error("result word changed while stalled");

  // only a successful pop returns a nonzero word
  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> popped_value_o == '0)
    else $error("nonzero popped value on a failed operation");

  // full reports the whole capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> stored_count_o == COUNT_W'(CAPACITY))
    else $error("full status with wrong count");

  // empty reports no entries
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> stored_count_o == '0)
    else $error("empty status with nonzero count");

endmodule

bind sorted_set_table_unit sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);
